// ===== src/trh_pkg.sv =====
package trh_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_SETPOINT    = 3'd0,
    CFG_HYSTERESIS  = 3'd1,
    CFG_INTERVAL_MS = 3'd2,
    CFG_MIN_ON_MS   = 3'd3,
    CFG_MIN_OFF_MS  = 3'd4
  } cfg_idx_t;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // Reset values of the configuration registers
  localparam logic signed [11:0] SetpointRst   = 12'sd352;
  localparam logic        [7:0]  HysteresisRst = 8'd8;
  localparam logic        [31:0] IntervalRst   = 32'd1000;
  localparam logic        [31:0] MinOnRst      = 32'd30000;
  localparam logic        [31:0] MinOffRst     = 32'd30000;

  // Fan thresholds above setpoint, 1/16 degree units (2.0 and 1.0 degrees)
  localparam logic signed [13:0] FanOnOffset  = 14'sd32;
  localparam logic signed [13:0] FanOffOffset = 14'sd16;

  // One result item
  typedef struct packed {
    logic heater_relay;
    logic fan_relay;
    logic evaluated;
    logic heater_switched;
    logic fan_switched;
  } out_item_t;

endpackage

// ===== src/trh_if.sv =====
// Input channel: one timestamped temperature sample per transfer
interface trh_in_if;
  logic               valid;
  logic               ready;
  logic        [31:0] time_ms;
  logic signed [11:0] temperature;
  logic               temp_valid;

  modport source (output valid, output time_ms, output temperature, output temp_valid,
                  input ready);
  modport sink   (input valid, input time_ms, input temperature, input temp_valid,
                  output ready);
endinterface

// Result channel: relay levels and status flags per transfer
interface trh_out_if;
  logic valid;
  logic ready;
  logic heater_relay;
  logic fan_relay;
  logic evaluated;
  logic heater_switched;
  logic fan_switched;

  modport source (output valid, output heater_relay, output fan_relay, output evaluated,
                  output heater_switched, output fan_switched, input ready);
  modport sink   (input valid, input heater_relay, input fan_relay, input evaluated,
                  input heater_switched, input fan_switched, output ready);
endinterface

// ===== src/thermostat_relay_hysteresis.sv =====
// Channel   Direction  Transfer when              Payload
// in_ch     input      in_ch.valid & in_ch.ready   time_ms, temperature, temp_valid
// out_ch    output     out_ch.valid & out_ch.ready relay levels, evaluated, switched flags
// cfg_*     input      cfg_we                      cfg_index, cfg_data (no read-back)
//
// One sample per cycle while in_ch.ready is high; each result is registered.
// Control state updates at the input transfer; the result lands in an output
// register backed by a one-entry skid register, so one result may wait while the
// next sample is taken. in_ch.ready drops only while the skid register is full.
// Synchronous active-low reset restores register defaults and relays off.
module thermostat_relay_hysteresis
  import trh_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  trh_in_if.sink              in_ch,
  trh_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // Configuration registers
  logic signed [11:0] setpoint_r;
  logic        [7:0]  hysteresis_r;
  logic        [31:0] interval_r;
  logic        [31:0] min_on_r;
  logic        [31:0] min_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r   <= SetpointRst;
      hysteresis_r <= HysteresisRst;
      interval_r   <= IntervalRst;
      min_on_r     <= MinOnRst;
      min_off_r    <= MinOffRst;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SETPOINT:    setpoint_r   <= cfg_data[11:0];
        CFG_HYSTERESIS:  hysteresis_r <= cfg_data[7:0];
        CFG_INTERVAL_MS: interval_r   <= cfg_data;
        CFG_MIN_ON_MS:   min_on_r     <= cfg_data;
        CFG_MIN_OFF_MS:  min_off_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control state
  logic [31:0] last_eval_r, last_eval_nxt;
  logic        heater_r, heater_nxt;
  logic        fan_r, fan_nxt;
  logic [31:0] heat_tgl_r, heat_tgl_nxt;
  logic [31:0] fan_tgl_r, fan_tgl_nxt;

  // Output register and skid register
  out_item_t out_r, out_nxt;
  out_item_t skid_r, skid_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;

  logic in_xfer;
  logic out_xfer;

  assign in_ch.ready = !skid_valid_r;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_valid_r && out_ch.ready;

  // Thresholds, 14-bit signed to cover setpoint plus or minus hysteresis
  logic signed [13:0] sp_ext;
  logic signed [13:0] hyst_ext;
  logic signed [13:0] temp_ext;
  logic signed [13:0] heat_lo;
  logic signed [13:0] heat_hi;
  logic signed [13:0] fan_on_th;
  logic signed [13:0] fan_off_th;

  assign sp_ext     = 14'(setpoint_r);
  assign hyst_ext   = $signed({6'd0, hysteresis_r});
  assign temp_ext   = 14'(in_ch.temperature);
  assign heat_lo    = sp_ext - hyst_ext;
  assign heat_hi    = sp_ext + hyst_ext;
  assign fan_on_th  = sp_ext + FanOnOffset;
  assign fan_off_th = sp_ext + FanOffOffset;

  // Wrapping time differences
  logic [31:0] since_eval;
  logic [31:0] heat_age;
  logic [31:0] fan_age;
  logic        due;
  logic        evaluated;
  logic        heat_sw;
  logic        fan_sw;

  assign since_eval = in_ch.time_ms - last_eval_r;
  assign heat_age   = in_ch.time_ms - heat_tgl_r;
  assign fan_age    = in_ch.time_ms - fan_tgl_r;
  assign due        = since_eval >= interval_r;
  assign evaluated  = due && in_ch.temp_valid;

  // Switch decisions, gated by minimum on/off time
  always_comb begin
    if (!heater_r) begin
      heat_sw = evaluated && (temp_ext <= heat_lo) && (heat_age >= min_off_r);
    end else begin
      heat_sw = evaluated && (temp_ext >= heat_hi) && (heat_age >= min_on_r);
    end
    if (!fan_r) begin
      fan_sw = evaluated && (temp_ext >= fan_on_th) && (fan_age >= min_off_r);
    end else begin
      fan_sw = evaluated && (temp_ext <= fan_off_th) && (fan_age >= min_on_r);
    end
  end

  // Next control state and result
  out_item_t res;

  always_comb begin
    last_eval_nxt = last_eval_r;
    heater_nxt    = heater_r;
    fan_nxt       = fan_r;
    heat_tgl_nxt  = heat_tgl_r;
    fan_tgl_nxt   = fan_tgl_r;
    if (in_xfer) begin
      if (due) begin
        last_eval_nxt = in_ch.time_ms;
      end
      if (heat_sw) begin
        heater_nxt   = !heater_r;
        heat_tgl_nxt = in_ch.time_ms;
      end
      if (fan_sw) begin
        fan_nxt     = !fan_r;
        fan_tgl_nxt = in_ch.time_ms;
      end
    end
    res.heater_relay    = heater_r ^ heat_sw;
    res.fan_relay       = fan_r ^ fan_sw;
    res.evaluated       = evaluated;
    res.heater_switched = heat_sw;
    res.fan_switched    = fan_sw;
  end

  // Output register / skid steering
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_xfer) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = in_xfer;
      end
    end else if (in_xfer) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_eval_r  <= '0;
      heater_r     <= 1'b0;
      fan_r        <= 1'b0;
      heat_tgl_r   <= '0;
      fan_tgl_r    <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      last_eval_r  <= last_eval_nxt;
      heater_r     <= heater_nxt;
      fan_r        <= fan_nxt;
      heat_tgl_r   <= heat_tgl_nxt;
      fan_tgl_r    <= fan_tgl_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.heater_relay    = out_r.heater_relay;
  assign out_ch.fan_relay       = out_r.fan_relay;
  assign out_ch.evaluated       = out_r.evaluated;
  assign out_ch.heater_switched = out_r.heater_switched;
  assign out_ch.fan_switched    = out_r.fan_switched;

  // Checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  a_switch_needs_eval: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.heater_switched || out_r.fan_switched) |-> out_r.evaluated)
    else $error("relay switched without evaluation");

  a_heater_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && heat_sw |=> heater_r != $past(heater_r) && heat_tgl_r == $past(in_ch.time_ms))
    else $error("heater switch not reflected in state");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_xfer |=> $stable(last_eval_r) && $stable(heater_r) && $stable(fan_r))
    else $error("control state changed without input transfer");

endmodule
